// ===== rtl/char_lcd_command_sequencer_defines.svh =====
// Assertion macros for the port-level checker of the LCD command sequencer.
// No dependencies.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_DEFINES_SVH

// antecedent true -> consequent in the same cycle
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent true -> consequent in the next cycle
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clcd_pkg.sv =====
// Types, codes and the microcode program of the LCD command sequencer.
// No dependencies; used by clcd_xfer and char_lcd_command_sequencer.
package clcd_pkg;

    localparam int COLUMNS = 16;
    localparam int IDX_W   = $clog2(COLUMNS);
    localparam int PCT     = 100;
    localparam int ACC_W   = $clog2(127 * COLUMNS + 1);
    localparam int PC_W    = 5;

    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_CLEAR  = 3'd1;
    localparam logic [2:0] REQ_CURSOR = 3'd2;
    localparam logic [2:0] REQ_CHAR   = 3'd3;
    localparam logic [2:0] REQ_BAR    = 3'd4;
    localparam logic [2:0] REQ_CLRROW = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_ARG = 2'd1;
    localparam logic [1:0] STAT_NO_INIT = 2'd2;
    localparam logic [1:0] STAT_RE_INIT = 2'd3;

    localparam logic [1:0] WAIT_NONE   = 2'd0;
    localparam logic [1:0] WAIT_150US  = 2'd1;
    localparam logic [1:0] WAIT_1600US = 2'd2;
    localparam logic [1:0] WAIT_10MS   = 2'd3;

    localparam logic [7:0] FS_8BIT    = 8'h38;
    localparam logic [7:0] FS_4BIT    = 8'h28;
    localparam logic [7:0] CMD_DISPON = 8'h0C;
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_ENTRY  = 8'h06;
    localparam logic [7:0] NIB_WAKE   = 8'h03;
    localparam logic [7:0] NIB_4BIT   = 8'h02;
    localparam logic [7:0] ROW1_BASE  = 8'h40;
    localparam logic [7:0] CMD_DDRAM  = 8'h80;
    localparam logic [7:0] CHAR_BLOCK = 8'hFF;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [PC_W-1:0] PC_INIT   = 5'd0;
    localparam logic [PC_W-1:0] PC_CLEAR  = 5'd10;
    localparam logic [PC_W-1:0] PC_CURSOR = 5'd11;
    localparam logic [PC_W-1:0] PC_CHAR   = 5'd12;
    localparam logic [PC_W-1:0] PC_BAR    = 5'd13;
    localparam logic [PC_W-1:0] PC_CLRROW = 5'd15;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_STATUS
    } seq_state_t;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_FS,
        SRC_CHAR,
        SRC_CURSOR,
        SRC_HOME,
        SRC_BAR
    } src_t;

    typedef struct packed {
        logic       is_byte;
        logic       rs;
        src_t       src;
        logic [7:0] value;
        logic [1:0] wait_code;
        logic       pu;
        logic       skip8;
        logic       loop;
        logic       fin;
    } uword_t;

    // one command from sequencer to transfer stage
    typedef struct packed {
        logic       xfer;
        logic       is_byte;
        logic       rs;
        logic [7:0] value;
        logic [1:0] wait_code;
        logic       pu;
        logic [1:0] status;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic       transfer_valid;
        logic       reg_select;
        logic [7:0] bus_value;
        logic       nibble_only;
        logic [1:0] wait_after;
        logic       power_up_wait;
        logic [1:0] status;
        logic       last;
    } res_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{is_byte: 1'b1, rs: 1'b0, src: SRC_CONST, value: 8'h00,
              wait_code: WAIT_NONE, pu: 1'b0, skip8: 1'b0, loop: 1'b0, fin: 1'b0};
        unique case (pc)
            5'd0:
            begin
                w.is_byte = 1'b0; w.value = NIB_WAKE; w.wait_code = WAIT_10MS; w.pu = 1'b1;
            end
            5'd1:
            begin
                w.is_byte = 1'b0; w.value = NIB_WAKE; w.wait_code = WAIT_10MS;
            end
            5'd2:
            begin
                w.is_byte = 1'b0; w.value = NIB_WAKE; w.wait_code = WAIT_150US;
            end
            5'd3:
            begin
                w.is_byte = 1'b0; w.value = NIB_4BIT; w.skip8 = 1'b1;
            end
            5'd4:
            begin
                w.src = SRC_FS; w.wait_code = WAIT_10MS;
            end
            5'd5:
            begin
                w.src = SRC_FS; w.wait_code = WAIT_150US;
            end
            5'd6:      w.src = SRC_FS;
            5'd7:      w.value = CMD_DISPON;
            5'd8:
            begin
                w.value = CMD_CLEAR; w.wait_code = WAIT_1600US;
            end
            5'd9:
            begin
                w.value = CMD_ENTRY; w.wait_code = WAIT_10MS; w.fin = 1'b1;
            end
            5'd10:
            begin
                w.value = CMD_CLEAR; w.wait_code = WAIT_1600US; w.fin = 1'b1;
            end
            5'd11:
            begin
                w.src = SRC_CURSOR; w.fin = 1'b1;
            end
            5'd12:
            begin
                w.src = SRC_CHAR; w.rs = 1'b1; w.fin = 1'b1;
            end
            5'd13:     w.src = SRC_HOME;
            5'd14:
            begin
                w.src = SRC_BAR; w.rs = 1'b1; w.loop = 1'b1; w.fin = 1'b1;
            end
            5'd15:     w.src = SRC_HOME;
            5'd16:
            begin
                w.value = CHAR_SPACE; w.rs = 1'b1; w.loop = 1'b1;
            end
            5'd17:
            begin
                w.src = SRC_HOME; w.fin = 1'b1;
            end
            default:   w.fin = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/clcd_xfer.sv =====
// Transfer stage: output register with valid/stall and 4-bit nibble split.
// Depends on clcd_pkg.
module clcd_xfer
    import clcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic bw8,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_ready,
    output logic out_valid,
    input  logic out_stall,
    output res_t res
);

    logic       ov_reg, ov_next;
    logic       pend_reg, pend_next;
    res_t       res_reg, res_next;
    res_t       lo_reg, lo_next;
    logic       free;
    logic       split;

    assign free      = ~ov_reg | ~out_stall;
    assign cmd_ready = free & ~pend_reg;
    assign split     = cmd.xfer & cmd.is_byte & ~bw8;

    always_comb
    begin
        ov_next   = ov_reg;
        pend_next = pend_reg;
        res_next  = res_reg;
        lo_next   = lo_reg;
        if (free)
        begin
            if (pend_reg)
            begin
                ov_next   = 1'b1;
                pend_next = 1'b0;
                res_next  = lo_reg;
            end
            else if (cmd_valid)
            begin
                ov_next                 = 1'b1;
                res_next.transfer_valid = cmd.xfer;
                res_next.reg_select     = cmd.rs;
                res_next.power_up_wait  = cmd.pu;
                res_next.status         = cmd.status;
                if (split)
                begin
                    pend_next              = 1'b1;
                    res_next.bus_value     = {4'b0, cmd.value[7:4]};
                    res_next.nibble_only   = 1'b1;
                    res_next.wait_after    = WAIT_NONE;
                    res_next.last          = 1'b0;
                    lo_next                = res_next;
                    lo_next.bus_value      = {4'b0, cmd.value[3:0]};
                    lo_next.wait_after     = cmd.wait_code;
                    lo_next.power_up_wait  = 1'b0;
                    lo_next.last           = cmd.last;
                end
                else
                begin
                    res_next.bus_value   = cmd.is_byte ? cmd.value : {4'b0, cmd.value[3:0]};
                    res_next.nibble_only = cmd.xfer & ~cmd.is_byte;
                    res_next.wait_after  = cmd.wait_code;
                    res_next.last        = cmd.last;
                end
            end
            else
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            ov_reg   <= ov_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        lo_reg  <= lo_next;
    end

    assign out_valid = ov_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/char_lcd_command_sequencer.sv =====
// Character LCD command sequencer top level: request decode, microcoded step sequencer,
// APB register. Depends on clcd_pkg and clcd_xfer.
// A request is first registered in the sequencer, then each result in the transfer stage output register.
// Throughput: one step per cycle unless the output stalls; a split byte in 4-bit mode holds
// the sequencer until its low nibble goes out, and a new request is taken only when it is idle.
// Reset: asynchronous, active low; display marked not initialized, bus width 8 bits.
module char_lcd_command_sequencer
    import clcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [1:0]  row,
    input  logic [4:0]  col,
    input  logic [7:0]  char_code,
    input  logic [6:0]  progress,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        transfer_valid,
    output logic        reg_select,
    output logic [7:0]  bus_value,
    output logic        nibble_only,
    output logic [1:0]  wait_after,
    output logic        power_up_wait,
    output logic [1:0]  status,
    output logic        last
);

    seq_state_t       state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ACC_W-1:0] thr_reg, thr_next;
    logic [ACC_W-1:0] x_reg, x_next;
    logic             row_reg, row_next;
    logic [4:0]       col_reg, col_next;
    logic [7:0]       char_reg, char_next;
    logic [1:0]       stat_reg, stat_next;
    logic             init_reg, init_next;
    logic             bw8_reg;

    logic             in_accept;
    logic             bad_arg;
    logic             dec_run;
    logic [1:0]       dec_stat;
    logic [PC_W-1:0]  dec_pc;
    uword_t           uw;
    logic             skip;
    logic             loop_more;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_t             cmd;
    res_t             res;
    logic             cfg_wr;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == 1'b0) ? {31'b0, bw8_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bw8_reg <= 1'b1;
        else if (cfg_wr && paddr[2] == 1'b0)
            bw8_reg <= pwdata[0];
    end

    assign in_stall  = (state_reg != SEQ_IDLE);
    assign in_accept = in_valid & ~in_stall;

    // request check
    always_comb
    begin
        bad_arg = 1'b0;
        unique case (req_type) inside
            REQ_CURSOR: bad_arg = row[1] | (ACC_W'(col) >= ACC_W'(COLUMNS));
            REQ_BAR:    bad_arg = row[1] | (progress > 7'(PCT));
            REQ_CLRROW: bad_arg = row[1];
            REQ_INIT, REQ_CLEAR, REQ_CHAR: bad_arg = 1'b0;
            default:    bad_arg = 1'b1;
        endcase
    end

    always_comb
    begin
        dec_run  = 1'b0;
        dec_stat = STAT_OK;
        dec_pc   = PC_INIT;
        if (bad_arg)
            dec_stat = STAT_BAD_ARG;
        else if (req_type == REQ_INIT)
        begin
            if (init_reg)
                dec_stat = STAT_RE_INIT;
            else
                dec_run = 1'b1;
        end
        else if (!init_reg)
            dec_stat = STAT_NO_INIT;
        else
        begin
            dec_run = 1'b1;
            unique case (req_type)
                REQ_CLEAR:  dec_pc = PC_CLEAR;
                REQ_CURSOR: dec_pc = PC_CURSOR;
                REQ_CHAR:   dec_pc = PC_CHAR;
                REQ_BAR:    dec_pc = PC_BAR;
                REQ_CLRROW: dec_pc = PC_CLRROW;
                default:    dec_pc = PC_INIT;
            endcase
        end
    end

    assign uw        = ucode(pc_reg);
    assign skip      = uw.skip8 & bw8_reg;
    assign loop_more = uw.loop & (idx_reg != IDX_W'(COLUMNS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        thr_next   = thr_reg;
        x_next     = x_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        char_next  = char_reg;
        stat_next  = stat_reg;
        init_next  = init_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    pc_next    = dec_pc;
                    idx_next   = '0;
                    thr_next   = ACC_W'(PCT);
                    x_next     = ACC_W'(progress) * ACC_W'(COLUMNS);
                    row_next   = row[0];
                    col_next   = col;
                    char_next  = char_code;
                    stat_next  = dec_stat;
                    state_next = dec_run ? SEQ_RUN : SEQ_STATUS;
                    if (dec_run && req_type == REQ_INIT)
                        init_next = 1'b1;
                end
            end
            SEQ_RUN:
            begin
                if (skip)
                    pc_next = pc_reg + 1'b1;
                else if (cmd_ready)
                begin
                    if (loop_more)
                    begin
                        idx_next = idx_reg + 1'b1;
                        thr_next = thr_reg + ACC_W'(PCT);
                    end
                    else
                    begin
                        idx_next = '0;
                        thr_next = ACC_W'(PCT);
                        if (uw.fin)
                            state_next = SEQ_IDLE;
                        else
                            pc_next = pc_reg + 1'b1;
                    end
                end
            end
            SEQ_STATUS:
            begin
                if (cmd_ready)
                    state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // command to transfer stage
    always_comb
    begin
        cmd_valid     = 1'b0;
        cmd.xfer      = 1'b1;
        cmd.is_byte   = uw.is_byte;
        cmd.rs        = uw.rs;
        cmd.wait_code = uw.wait_code;
        cmd.pu        = uw.pu;
        cmd.status    = STAT_OK;
        cmd.last      = uw.fin & ~loop_more;
        unique case (uw.src)
            SRC_FS:     cmd.value = bw8_reg ? FS_8BIT : FS_4BIT;
            SRC_CHAR:   cmd.value = char_reg;
            SRC_CURSOR: cmd.value = CMD_DDRAM + (row_reg ? ROW1_BASE : 8'h00) + 8'(col_reg);
            SRC_HOME:   cmd.value = CMD_DDRAM + (row_reg ? ROW1_BASE : 8'h00);
            SRC_BAR:    cmd.value = (thr_reg <= x_reg) ? CHAR_BLOCK : CHAR_SPACE;
            default:    cmd.value = uw.value;
        endcase
        unique case (state_reg)
            SEQ_RUN:    cmd_valid = ~skip;
            SEQ_STATUS:
            begin
                cmd_valid     = 1'b1;
                cmd.xfer      = 1'b0;
                cmd.is_byte   = 1'b0;
                cmd.rs        = 1'b0;
                cmd.value     = 8'h00;
                cmd.wait_code = WAIT_NONE;
                cmd.pu        = 1'b0;
                cmd.status    = stat_reg;
                cmd.last      = 1'b1;
            end
            default:    cmd_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            init_reg  <= 1'b0;
            pc_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        thr_reg  <= thr_next;
        x_reg    <= x_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        char_reg <= char_next;
        stat_reg <= stat_next;
    end

    clcd_xfer u_xfer (
        .clk       (clk),
        .rst_n     (rst_n),
        .bw8       (bw8_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign transfer_valid = res.transfer_valid;
    assign reg_select     = res.reg_select;
    assign bus_value      = res.bus_value;
    assign nibble_only    = res.nibble_only;
    assign wait_after     = res.wait_after;
    assign power_up_wait  = res.power_up_wait;
    assign status         = res.status;
    assign last           = res.last;

endmodule

// ===== rtl/clcd_checker.sv =====
// Port-level checks for the LCD command sequencer, bound to the top level.
// Depends on clcd_pkg and char_lcd_command_sequencer_defines.svh.
`include "char_lcd_command_sequencer_defines.svh"

module clcd_checker
    import clcd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       transfer_valid,
    input logic [7:0] bus_value,
    input logic       nibble_only,
    input logic       power_up_wait,
    input logic [1:0] status,
    input logic       last
);

    `CLCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(bus_value) && $stable(last), "stalled transaction changed")
    `CLCD_ASSERT_NOW(a_status_single, clk, rst_n, out_valid && !transfer_valid,
        last && status != STAT_OK, "status-only result must be a final error")
    `CLCD_ASSERT_NOW(a_xfer_ok, clk, rst_n, out_valid && transfer_valid,
        status == STAT_OK && (!nibble_only || bus_value[7:4] == 4'h0), "bad transfer payload")
    `CLCD_ASSERT_NOW(a_pu_nibble, clk, rst_n, out_valid && power_up_wait,
        transfer_valid && nibble_only && !last, "power-up wait only on first init nibble")

endmodule

bind char_lcd_command_sequencer clcd_checker u_clcd_checker (.*);

// ===== sim/char_lcd_command_sequencer_checker.sv =====
// Checker for the LCD command sequencer: follows register writes and request transactions,
// predicts each bus transfer and refusal and compares every result transaction. Depends on clcd_pkg.
module char_lcd_command_sequencer_checker
    import clcd_pkg::*;
#(
    parameter logic [2:0] BUS_WIDTH_ADDR = 3'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [1:0]  row,
    input  logic [4:0]  col,
    input  logic [7:0]  char_code,
    input  logic [6:0]  progress,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        transfer_valid,
    input  logic        reg_select,
    input  logic [7:0]  bus_value,
    input  logic        nibble_only,
    input  logic [1:0]  wait_after,
    input  logic        power_up_wait,
    input  logic [1:0]  status,
    input  logic        last,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic wide_bus;
    logic display_ready;
    res_t xfer_expected[$];
    int   mismatch_total;
    int   results_seen;

    assign mismatches = mismatch_total;

    task automatic report_mismatch(string msg);
        mismatch_total++;
        if (mismatch_total <= 40)
        begin
            $display("ERROR %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
        begin
            report_mismatch($sformatf("transaction %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    function automatic void plan_xfer(logic rs, logic [7:0] value, logic nib,
                                      logic [1:0] wcode, logic pu);
        res_t r;
        r.transfer_valid = 1'b1;
        r.reg_select     = rs;
        r.bus_value      = value;
        r.nibble_only    = nib;
        r.wait_after     = wcode;
        r.power_up_wait  = pu;
        r.status         = STAT_OK;
        r.last           = 1'b0;
        xfer_expected.push_back(r);
    endfunction

    function automatic void plan_byte(logic rs, logic [7:0] value, logic [1:0] wcode);
        if (wide_bus)
        begin
            plan_xfer(rs, value, 1'b0, wcode, 1'b0);
        end
        else
        begin
            plan_xfer(rs, {4'h0, value[7:4]}, 1'b1, WAIT_NONE, 1'b0);
            plan_xfer(rs, {4'h0, value[3:0]}, 1'b1, wcode, 1'b0);
        end
    endfunction

    function automatic void plan_cursor(logic [1:0] r, logic [4:0] c);
        logic [7:0] addr;
        addr = (r == 2'd0) ? {3'b000, c} : ROW1_BASE + {3'b000, c};
        plan_byte(1'b0, CMD_DDRAM | addr, WAIT_NONE);
    endfunction

    function automatic void plan_refusal(logic [1:0] st);
        res_t r;
        r = '0;
        r.status = st;
        xfer_expected.push_back(r);
    endfunction

    function automatic void plan_request(logic [2:0] req, logic [1:0] r, logic [4:0] c,
                                         logic [7:0] ch, logic [6:0] pct);
        logic       bad;
        logic [7:0] fs;
        int         blocks;
        res_t       tail;
        bad = 1'b0;
        fs = wide_bus ? FS_8BIT : FS_4BIT;
        blocks = (int'(pct) * COLUMNS) / PCT;
        if (req == REQ_CURSOR)
            bad = (r >= 2'd2) || (int'(c) >= COLUMNS);
        else if (req == REQ_BAR)
            bad = (r >= 2'd2) || (int'(pct) > PCT);
        else if (req == REQ_CLRROW)
            bad = (r >= 2'd2);

        if (req > REQ_CLRROW)
        begin
            plan_refusal(STAT_BAD_ARG);
        end
        else if (req == REQ_INIT)
        begin
            if (display_ready)
            begin
                plan_refusal(STAT_RE_INIT);
            end
            else
            begin
                plan_xfer(1'b0, NIB_WAKE, 1'b1, WAIT_10MS, 1'b1);
                plan_xfer(1'b0, NIB_WAKE, 1'b1, WAIT_10MS, 1'b0);
                plan_xfer(1'b0, NIB_WAKE, 1'b1, WAIT_150US, 1'b0);
                if (!wide_bus)
                    plan_xfer(1'b0, NIB_4BIT, 1'b1, WAIT_NONE, 1'b0);
                plan_byte(1'b0, fs, WAIT_10MS);
                plan_byte(1'b0, fs, WAIT_150US);
                plan_byte(1'b0, fs, WAIT_NONE);
                plan_byte(1'b0, CMD_DISPON, WAIT_NONE);
                plan_byte(1'b0, CMD_CLEAR, WAIT_1600US);
                plan_byte(1'b0, CMD_ENTRY, WAIT_10MS);
                display_ready = 1'b1;
            end
        end
        else if (bad)
        begin
            plan_refusal(STAT_BAD_ARG);
        end
        else if (!display_ready)
        begin
            plan_refusal(STAT_NO_INIT);
        end
        else if (req == REQ_CLEAR)
        begin
            plan_byte(1'b0, CMD_CLEAR, WAIT_1600US);
        end
        else if (req == REQ_CURSOR)
        begin
            plan_cursor(r, c);
        end
        else if (req == REQ_CHAR)
        begin
            plan_byte(1'b1, ch, WAIT_NONE);
        end
        else if (req == REQ_BAR)
        begin
            plan_cursor(r, 5'd0);
            for (int i = 0; i < COLUMNS; i++)
                plan_byte(1'b1, (i < blocks) ? CHAR_BLOCK : CHAR_SPACE, WAIT_NONE);
        end
        else
        begin
            plan_cursor(r, 5'd0);
            for (int i = 0; i < COLUMNS; i++)
                plan_byte(1'b1, CHAR_SPACE, WAIT_NONE);
            plan_cursor(r, 5'd0);
        end

        tail = xfer_expected[xfer_expected.size() - 1];
        tail.last = 1'b1;
        xfer_expected[xfer_expected.size() - 1] = tail;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            wide_bus = 1'b1;
            display_ready = 1'b0;
            xfer_expected.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == BUS_WIDTH_ADDR)
                wide_bus = pwdata[0];

            if (out_valid && !out_stall)
            begin
                got = {transfer_valid, reg_select, bus_value, nibble_only, wait_after,
                       power_up_wait, status, last};
                if (xfer_expected.size() == 0)
                begin
                    report_mismatch($sformatf("transaction %0d not expected: %h",
                                              results_seen, got));
                end
                else
                begin
                    want = xfer_expected.pop_front();
                    check_field("transfer_valid", got.transfer_valid, want.transfer_valid);
                    check_field("reg_select", got.reg_select, want.reg_select);
                    check_field("bus_value", got.bus_value, want.bus_value);
                    check_field("nibble_only", got.nibble_only, want.nibble_only);
                    check_field("wait_after", got.wait_after, want.wait_after);
                    check_field("power_up_wait", got.power_up_wait, want.power_up_wait);
                    check_field("status", got.status, want.status);
                    check_field("last", got.last, want.last);
                end
                results_seen++;
            end

            if (in_valid && !in_stall)
                plan_request(req_type, row, col, char_code, progress);

            pending <= xfer_expected.size();
        end
    end

endmodule

// ===== sim/char_lcd_command_sequencer_test.sv =====
// Testbench top for the LCD command sequencer: clock, reset, register writes, request
// stimulus and output stalls, final verdict. Depends on clcd_pkg and the checker module.
module char_lcd_command_sequencer_test;
    import clcd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] BUS_WIDTH_ADDR = 3'd0;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [2:0]  req_type  = '0;
    logic [1:0]  row       = '0;
    logic [4:0]  col       = '0;
    logic [7:0]  char_code = '0;
    logic [6:0]  progress  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        transfer_valid;
    logic        reg_select;
    logic [7:0]  bus_value;
    logic        nibble_only;
    logic [1:0]  wait_after;
    logic        power_up_wait;
    logic [1:0]  status;
    logic        last;
    int          mismatches;
    int          pending;

    int          send_left;
    bit          send_calm;
    int          take_left;
    bit          take_calm;

    char_lcd_command_sequencer i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .row(row), .col(col), .char_code(char_code),
        .progress(progress),
        .out_valid(out_valid), .out_stall(out_stall),
        .transfer_valid(transfer_valid), .reg_select(reg_select), .bus_value(bus_value),
        .nibble_only(nibble_only), .wait_after(wait_after), .power_up_wait(power_up_wait),
        .status(status), .last(last)
    );

    char_lcd_command_sequencer_checker #(.BUS_WIDTH_ADDR(BUS_WIDTH_ADDR)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .row(row), .col(col), .char_code(char_code),
        .progress(progress),
        .out_valid(out_valid), .out_stall(out_stall),
        .transfer_valid(transfer_valid), .reg_select(reg_select), .bus_value(bus_value),
        .nibble_only(nibble_only), .wait_after(wait_after), .power_up_wait(power_up_wait),
        .status(status), .last(last),
        .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // each stretch is drawn at random as back-to-back traffic or as random pauses
    function automatic int draw_pause(inout int stretch_left, inout bit calm);
        if (stretch_left == 0)
        begin
            stretch_left = $urandom_range(8, 40);
            calm = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic set_bus_width(logic wide);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BUS_WIDTH_ADDR;
        pwdata  <= {31'($urandom()), wide};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_request(logic [2:0] req, logic [1:0] r, logic [4:0] c,
                                logic [7:0] ch, logic [6:0] pct);
        int gap;
        gap = draw_pause(send_left, send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        row       <= r;
        col       <= c;
        char_code <= ch;
        progress  <= pct;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random_request();
        logic [2:0] req;
        logic [1:0] r;
        logic [4:0] c;
        logic [7:0] ch;
        logic [6:0] pct;
        int         pick;
        req  = 3'($urandom_range(1, 5));
        r    = 2'($urandom());
        c    = 5'($urandom());
        ch   = 8'($urandom());
        pct  = 7'($urandom());
        pick = $urandom_range(0, 99);
        if (pick >= 15)
        begin
            r[1] = 1'b0;
            c[4] = 1'b0;
            pct  = 7'($urandom_range(0, PCT));
        end
        if (pick < 4)
            req = 3'($urandom_range(6, 7));
        else if (pick < 7)
            req = REQ_INIT;
        send_request(req, r, c, ch, pct);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int w;
        @(posedge clk);
        forever
        begin
            w = draw_pause(take_left, take_calm);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before init: not-initialized refusals, argument check wins
        send_request(REQ_CLEAR, 2'd0, 5'd0, 8'h00, 7'd0);
        send_request(REQ_CHAR, 2'd3, 5'd31, 8'hFF, 7'd127);
        send_request(REQ_CURSOR, 2'd3, 5'd31, 8'h00, 7'd0);
        send_request(3'd6, 2'd0, 5'd0, 8'h00, 7'd0);
        send_request(3'd7, 2'd3, 5'd31, 8'hFF, 7'd127);
        send_request(REQ_BAR, 2'd0, 5'd0, 8'h00, 7'd101);
        send_request(REQ_BAR, 2'd0, 5'd0, 8'h00, 7'd127);
        send_request(REQ_CLRROW, 2'd2, 5'd0, 8'h00, 7'd0);
        send_request(REQ_CURSOR, 2'd0, 5'd16, 8'h00, 7'd0);
        send_request(REQ_CURSOR, 2'd1, 5'd15, 8'h00, 7'd0);
        drain();

        set_bus_width(1'($urandom_range(0, 1)));
        send_request(REQ_INIT, 2'd0, 5'd0, 8'h00, 7'd0);
        send_request(REQ_INIT, 2'd3, 5'd31, 8'hFF, 7'd127);
        send_request(REQ_CLEAR, 2'd0, 5'd0, 8'h00, 7'd0);
        send_request(REQ_CURSOR, 2'd0, 5'd0, 8'h00, 7'd0);
        send_request(REQ_CURSOR, 2'd1, 5'd15, 8'h00, 7'd0);
        send_request(REQ_CHAR, 2'd0, 5'd0, 8'h00, 7'd0);
        send_request(REQ_CHAR, 2'd0, 5'd0, 8'hFF, 7'd0);
        send_request(REQ_BAR, 2'd0, 5'd0, 8'h00, 7'd0);
        send_request(REQ_BAR, 2'd1, 5'd0, 8'h00, 7'd100);
        send_request(REQ_BAR, 2'd1, 5'd0, 8'h00, 7'd50);
        send_request(REQ_BAR, 2'd0, 5'd0, 8'h00, 7'd99);
        send_request(REQ_CLRROW, 2'd0, 5'd0, 8'h00, 7'd0);
        send_request(REQ_CLRROW, 2'd1, 5'd0, 8'h00, 7'd0);
        send_request(REQ_CURSOR, 2'd2, 5'd0, 8'h00, 7'd0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_bus_width(1'b0);
            else if (phase == 1)
                set_bus_width(1'b1);
            else
                set_bus_width(1'($urandom_range(0, 1)));
            for (int n = 0; n < 56; n++)
                send_random_request();
            drain();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== char_lcd_command_sequencer.f =====
+incdir+rtl
rtl/clcd_pkg.sv
rtl/clcd_xfer.sv
rtl/char_lcd_command_sequencer.sv
rtl/clcd_checker.sv
sim/char_lcd_command_sequencer_checker.sv
sim/char_lcd_command_sequencer_test.sv
